### hw/rtl/bouncing_glyph_scroller_frame_unit_defines.svh
// ----------------------------------------------------------------------------
// Bouncing glyph scroller assertion macros
// Shared concurrent assertion forms used by the scroller RTL.
// ----------------------------------------------------------------------------
`ifndef BOUNCING_GLYPH_SCROLLER_FRAME_UNIT_DEFINES_SVH
`define BOUNCING_GLYPH_SCROLLER_FRAME_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BGS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BGS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/bgs_pkg.sv
// ----------------------------------------------------------------------------
// Bouncing glyph scroller package
// Constants, slot and control types, and the bounce curve generator.
// ----------------------------------------------------------------------------
`default_nettype none

package bgs_pkg;

   localparam int MAX_LETTERS   = 64;
   localparam int SCREEN_HEIGHT = 240;
   localparam int ROM_LEN       = 540;
   localparam int PHASE_STEP    = 8;
   localparam int MOVE_STEP     = 3;
   localparam int SPAWN_LIMIT   = 20;
   localparam int SPAWN_STEP    = 2;
   localparam int SPAWN_THRESH  = SPAWN_LIMIT / SPAWN_STEP;
   localparam longint unsigned ANG_STEP_Q30 = 64'd18740231;

   localparam int SW_W        = 10;
   localparam int CW_W        = 7;
   localparam int LS_W        = 7;
   localparam int GLYPH_W     = 12;
   localparam int POS_W       = 12;
   localparam int PHASE_W     = $clog2(ROM_LEN);
   localparam int SRC_W       = 14;
   localparam int DX_W        = 10;
   localparam int DY_W        = 8;
   localparam int SPAWN_CNT_W = 5;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 10;

   localparam int SLOT_W    = (MAX_LETTERS > 1) ? $clog2(MAX_LETTERS) : 1;
   localparam int CMP_W     = (SLOT_W > LS_W) ? SLOT_W : LS_W;
   localparam int GRP_SIZE  = 8;
   localparam int GRP_SEL_W = $clog2(GRP_SIZE);
   localparam int NGROUP    = (MAX_LETTERS + GRP_SIZE - 1) / GRP_SIZE;
   localparam int GRP_W     = (NGROUP > 1) ? $clog2(NGROUP) : 1;
   localparam int IDX_W     = GRP_W + GRP_SEL_W;

   localparam logic [POS_W-1:0] POS_FREE = {1'b1, {(POS_W-1){1'b0}}};

   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHAR_WIDTH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LETTER_SLOTS = 2'd2;

   typedef struct packed {
      logic signed [POS_W-1:0] pos;
      logic [PHASE_W-1:0]      phase;
      logic [GLYPH_W-1:0]      glyph_x;
   } slot_type;

   typedef struct packed {
      logic step;
      logic active;
      logic flush;
      logic taken;
   } emit_ctrl_type;

   typedef struct packed {
      logic step_ok;
      logic flush_ok;
   } emit_stat_type;

   typedef logic [DY_W-1:0] bounce_rom_type [ROM_LEN];

   // Q16 sine magnitude of an angle in degrees, 0..90, from a truncating
   // Horner evaluation of the odd Taylor series in Q30.
   function automatic logic [15:0] sin_q16(input logic [6:0] a);
      logic [63:0] one;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] d;
      logic [63:0] s;
      logic [63:0] m;
      one = 64'd1 << 30;
      x   = 64'(a) * ANG_STEP_Q30;
      x2  = (x * x) >> 30;
      t   = one;
      d   = ((x2 * t) >> 30) / 64'd110;
      t   = (d > one) ? 64'd0 : one - d;
      d   = ((x2 * t) >> 30) / 64'd72;
      t   = (d > one) ? 64'd0 : one - d;
      d   = ((x2 * t) >> 30) / 64'd42;
      t   = (d > one) ? 64'd0 : one - d;
      d   = ((x2 * t) >> 30) / 64'd20;
      t   = (d > one) ? 64'd0 : one - d;
      d   = ((x2 * t) >> 30) / 64'd6;
      t   = (d > one) ? 64'd0 : one - d;
      s   = (x * t) >> 30;
      m   = s >> 14;
      return (m > 64'd65535) ? 16'hFFFF : m[15:0];
   endfunction

   function automatic logic [DY_W-1:0] bounce_y(input int n);
      logic [PHASE_W-1:0] d;
      logic [6:0]         a;
      logic               neg;
      logic [63:0]        prod;
      logic [31:0]        mag;
      logic [31:0]        c;
      logic [31:0]        y;
      d = (n < 360) ? PHASE_W'(n >> 1) : PHASE_W'(n - 180);
      if (d <= PHASE_W'(90)) begin
         a   = 7'(d);
         neg = 1'b0;
      end else if (d <= PHASE_W'(180)) begin
         a   = 7'(PHASE_W'(180) - d);
         neg = 1'b0;
      end else if (d <= PHASE_W'(270)) begin
         a   = 7'(d - PHASE_W'(180));
         neg = 1'b1;
      end else begin
         a   = 7'(PHASE_W'(360) - d);
         neg = 1'b1;
      end
      prod = (64'(sin_q16(a)) * 64'(SCREEN_HEIGHT)) >> 17;
      mag  = prod[31:0];
      c    = 32'(SCREEN_HEIGHT / 2);
      if (neg) begin
         y = c + mag;
      end else begin
         y = (mag > c) ? 32'd0 : c - mag;
      end
      return y[DY_W-1:0];
   endfunction

   function automatic bounce_rom_type build_bounce_rom();
      bounce_rom_type r;
      for (int n = 0; n < ROM_LEN; n++) begin
         r[n] = bounce_y(n);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/bgs_channel_if.sv
// ----------------------------------------------------------------------------
// Bouncing glyph scroller channels
// Frame tick channel and draw item channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface bgs_req_if;
   import bgs_pkg::*;

   logic               valid;
   logic               ready;
   logic [GLYPH_W-1:0] next_glyph_x;

   modport source (output valid, output next_glyph_x, input ready);
   modport sink   (input valid, input next_glyph_x, output ready);
endinterface

interface bgs_rsp_if;
   import bgs_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    item_valid;
   logic signed [SRC_W-1:0] source_x;
   logic [CW_W-1:0]         draw_width;
   logic [DX_W-1:0]         dest_x;
   logic [DY_W-1:0]         dest_y;
   logic                    glyph_taken;
   logic                    last_item;

   modport source (
      output valid, output item_valid, output source_x, output draw_width,
      output dest_x, output dest_y, output glyph_taken, output last_item,
      input ready
   );
   modport sink (
      input valid, input item_valid, input source_x, input draw_width,
      input dest_x, input dest_y, input glyph_taken, input last_item,
      output ready
   );
endinterface

`default_nettype wire

### hw/rtl/bgs_cell.sv
// ----------------------------------------------------------------------------
// Bouncing glyph scroller slot cell
// Holds one letter slot, flags it free, loads a new glyph, shifts along.
// ----------------------------------------------------------------------------
`default_nettype none

module bgs_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           shift_en,
   input  logic                           load_en,
   input  logic [bgs_pkg::SW_W-1:0]       load_pos,
   input  logic [bgs_pkg::GLYPH_W-1:0]    load_glyph,
   input  logic signed [bgs_pkg::POS_W-1:0] neg_cw,
   input  bgs_pkg::slot_type              nbr_in,
   output bgs_pkg::slot_type              slot_out,
   output logic                           free
);
   import bgs_pkg::*;

   slot_type slot_ff;
   slot_type slot_in;

   always_comb begin
      slot_in = slot_ff;
      if (load_en) begin
         slot_in.pos     = POS_W'(load_pos);
         slot_in.phase   = '0;
         slot_in.glyph_x = load_glyph;
      end else if (shift_en) begin
         slot_in = nbr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.pos   <= POS_FREE;
         slot_ff.phase <= '0;
      end else begin
         slot_ff <= slot_in;
      end
   end

   assign slot_out = slot_ff;
   assign free     = slot_ff.pos < neg_cw;

endmodule

`default_nettype wire

### hw/rtl/bgs_emit.sv
// ----------------------------------------------------------------------------
// Bouncing glyph scroller head unit
// Moves the slot at the head of the chain, clips it and builds draw beats.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bouncing_glyph_scroller_frame_unit_defines.svh"

module bgs_emit (
   input  logic                             clock,
   input  logic                             reset,
   input  bgs_pkg::slot_type                head_slot,
   input  logic signed [bgs_pkg::POS_W-1:0] neg_cw,
   input  logic [bgs_pkg::CW_W-1:0]         char_width,
   input  bgs_pkg::emit_ctrl_type           ctrl,
   output bgs_pkg::slot_type                head_next,
   output bgs_pkg::emit_stat_type           stat,
   bgs_rsp_if.source                        rsp_ch
);
   import bgs_pkg::*;

   localparam int PSUM_W = PHASE_W + 1;
   localparam bounce_rom_type BOUNCE_ROM = build_bounce_rom();

   logic                    move;
   logic                    visible;
   logic                    vis;
   logic                    clip;
   logic                    out_load;
   logic signed [POS_W-1:0] pos_n;
   logic [PSUM_W-1:0]       phase_sum;
   logic [PHASE_W-1:0]      phase_n;
   logic [POS_W-1:0]        w_sum;
   logic [SRC_W-1:0]        src_x;
   logic [CW_W-1:0]         w;
   logic [DX_W-1:0]         dx;

   logic             p_valid_ff;
   logic [SRC_W-1:0] p_src_ff;
   logic [CW_W-1:0]  p_w_ff;
   logic [DX_W-1:0]  p_dx_ff;
   logic [DY_W-1:0]  p_dy_ff;

   logic             out_valid_ff;
   logic             out_item_ff;
   logic [SRC_W-1:0] out_src_ff;
   logic [CW_W-1:0]  out_w_ff;
   logic [DX_W-1:0]  out_dx_ff;
   logic [DY_W-1:0]  out_dy_ff;
   logic             out_taken_ff;
   logic             out_last_ff;

   always_comb begin
      move      = head_slot.pos >= neg_cw;
      pos_n     = move ? head_slot.pos - POS_W'(MOVE_STEP) : head_slot.pos;
      visible   = pos_n > neg_cw;
      vis       = ctrl.active && visible;
      phase_sum = {1'b0, head_slot.phase} + PSUM_W'(PHASE_STEP);
      phase_n   = (phase_sum >= PSUM_W'(ROM_LEN)) ?
                  PHASE_W'(phase_sum - PSUM_W'(ROM_LEN)) : phase_sum[PHASE_W-1:0];
      clip      = pos_n[POS_W-1];
      w_sum     = POS_W'(char_width) + pos_n;
      // skip the columns hidden past the left border
      src_x     = SRC_W'(head_slot.glyph_x) - SRC_W'(1) -
                  (clip ? {{(SRC_W-POS_W){pos_n[POS_W-1]}}, pos_n} : SRC_W'(0));
      w         = clip ? w_sum[CW_W-1:0] : char_width;
      dx        = clip ? DX_W'(0) : pos_n[DX_W-1:0];

      head_next = head_slot;
      if (ctrl.active) begin
         head_next.pos = pos_n;
      end
      if (vis) begin
         head_next.phase = phase_n;
      end

      // a held beat leaves once the next visible slot proves it is not last
      out_load = (ctrl.step && vis && p_valid_ff) || ctrl.flush;
   end

   assign stat.flush_ok = !out_valid_ff || rsp_ch.ready;
   assign stat.step_ok  = !out_valid_ff || rsp_ch.ready || !p_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (ctrl.step && vis) begin
            p_valid_ff <= 1'b1;
         end else if (ctrl.flush) begin
            p_valid_ff <= 1'b0;
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.step && vis) begin
         p_src_ff <= src_x;
         p_w_ff   <= w;
         p_dx_ff  <= dx;
         p_dy_ff  <= BOUNCE_ROM[phase_n];
      end
      if (out_load) begin
         out_taken_ff <= ctrl.taken;
         out_last_ff  <= ctrl.flush;
         if (ctrl.flush && !p_valid_ff) begin
            out_item_ff <= 1'b0;
            out_src_ff  <= '0;
            out_w_ff    <= '0;
            out_dx_ff   <= '0;
            out_dy_ff   <= '0;
         end else begin
            out_item_ff <= 1'b1;
            out_src_ff  <= p_src_ff;
            out_w_ff    <= p_w_ff;
            out_dx_ff   <= p_dx_ff;
            out_dy_ff   <= p_dy_ff;
         end
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.item_valid  = out_item_ff;
   assign rsp_ch.source_x    = out_src_ff;
   assign rsp_ch.draw_width  = out_w_ff;
   assign rsp_ch.dest_x      = out_dx_ff;
   assign rsp_ch.dest_y      = out_dy_ff;
   assign rsp_ch.glyph_taken = out_taken_ff;
   assign rsp_ch.last_item   = out_last_ff;

   `BGS_ASSERT_NOW(a_step_flush_apart, clock, reset, ctrl.step, !ctrl.flush, "step and flush together")
   `BGS_ASSERT_NOW(a_unclipped_width, clock, reset, p_valid_ff && (p_dx_ff != '0), p_w_ff == char_width, "unclipped glyph width differs")
   `BGS_ASSERT_NOW(a_empty_beat, clock, reset, out_valid_ff && !out_item_ff, out_last_ff && (out_w_ff == '0) && (out_dx_ff == '0), "empty frame beat malformed")

endmodule

`default_nettype wire

### hw/rtl/bouncing_glyph_scroller_frame_unit.sv
// ----------------------------------------------------------------------------
// Bouncing glyph scroller frame unit
// One frame beat: free-slot search in the flags, groups and spawn states, then
// MAX_LETTERS (64) steps of slot rotation through the head unit, then a flush
// that ends the item stream; the next frame beat is taken only back in idle.
// Rate is set by the ring moving one slot past the head unit per cycle, save while the output stalls.
// Reset is synchronous: registers go to 320/8/40, all slots free, no sweep.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bouncing_glyph_scroller_frame_unit_defines.svh"

module bouncing_glyph_scroller_frame_unit (
   input  logic                               clock,
   input  logic                               reset,
   bgs_req_if.sink                            req_ch,
   bgs_rsp_if.source                          rsp_ch,
   input  logic                               csr_we,
   input  logic [bgs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bgs_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import bgs_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FLAGS,
      ST_GROUPS,
      ST_SPAWN,
      ST_ROTATE,
      ST_FLUSH
   } state_type;

   state_type state_ff;

   logic [SW_W-1:0]        screen_width_ff;
   logic [CW_W-1:0]        char_width_ff;
   logic [LS_W-1:0]        letter_slots_ff;
   logic [SPAWN_CNT_W-1:0] spawn_counter_ff;
   logic                   taken_ff;
   logic [SLOT_W-1:0]      rot_cnt_ff;
   logic [GLYPH_W-1:0]     glyph_ff;

   logic [NGROUP*GRP_SIZE-1:0] free_ff;
   logic [NGROUP*GRP_SIZE-1:0] free_in;
   logic [NGROUP-1:0]          grp_any_ff;
   logic [NGROUP-1:0]          grp_any_in;
   logic [GRP_SEL_W-1:0]       grp_idx_ff [NGROUP];
   logic [GRP_SEL_W-1:0]       grp_idx_in [NGROUP];

   logic signed [POS_W-1:0] neg_cw;
   logic                    spawn_go;
   logic                    found;
   logic [IDX_W-1:0]        spawn_idx;
   logic [MAX_LETTERS-1:0]  load_vec;
   logic [MAX_LETTERS-1:0]  cell_free;
   logic                    step;
   logic                    pass_last;

   slot_type      chain [MAX_LETTERS+1];
   slot_type      head_next;
   emit_ctrl_type ctrl;
   emit_stat_type stat;

   assign neg_cw   = POS_W'(0) - POS_W'(char_width_ff);
   assign spawn_go = spawn_counter_ff > SPAWN_CNT_W'(SPAWN_THRESH);
   assign step     = (state_ff == ST_ROTATE) && stat.step_ok;
   assign pass_last = step && (rot_cnt_ff == SLOT_W'(MAX_LETTERS - 1));

   assign req_ch.ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff <= SW_W'(320);
         char_width_ff   <= CW_W'(8);
         letter_slots_ff <= LS_W'(40);
      end else if (csr_we) begin
         case (csr_index)
            CSR_SCREEN_WIDTH: screen_width_ff <= csr_wdata[SW_W-1:0];
            CSR_CHAR_WIDTH:   char_width_ff   <= csr_wdata[CW_W-1:0];
            CSR_LETTER_SLOTS: letter_slots_ff <= csr_wdata[LS_W-1:0];
            default: ;
         endcase
      end
   end

   // free-slot search, stage one: mask the cell flags to the slots in use
   always_comb begin
      free_in = '0;
      for (int i = 0; i < MAX_LETTERS; i++) begin
         free_in[i] = cell_free[i] && (CMP_W'(i) < CMP_W'(letter_slots_ff));
      end
   end

   // stage two: first free slot within each group of eight
   always_comb begin
      for (int g = 0; g < NGROUP; g++) begin
         grp_any_in[g] = |free_ff[g*GRP_SIZE +: GRP_SIZE];
         grp_idx_in[g] = '0;
         for (int b = GRP_SIZE - 1; b >= 0; b--) begin
            if (free_ff[g*GRP_SIZE + b]) begin
               grp_idx_in[g] = GRP_SEL_W'(b);
            end
         end
      end
   end

   // stage three: first group holding a free slot
   always_comb begin
      found     = 1'b0;
      spawn_idx = '0;
      for (int g = NGROUP - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            found     = 1'b1;
            spawn_idx = {GRP_W'(g), grp_idx_ff[g]};
         end
      end
      for (int i = 0; i < MAX_LETTERS; i++) begin
         load_vec[i] = (state_ff == ST_SPAWN) && spawn_go && found &&
                       (spawn_idx == IDX_W'(i));
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         glyph_ff <= req_ch.next_glyph_x;
      end
      if (state_ff == ST_FLAGS) begin
         free_ff <= free_in;
      end
      if (state_ff == ST_GROUPS) begin
         grp_any_ff <= grp_any_in;
         grp_idx_ff <= grp_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         spawn_counter_ff <= '0;
         taken_ff         <= 1'b0;
         rot_cnt_ff       <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_ch.valid) begin
                  state_ff <= ST_FLAGS;
               end
            end
            ST_FLAGS: begin
               state_ff <= ST_GROUPS;
            end
            ST_GROUPS: begin
               state_ff <= ST_SPAWN;
            end
            ST_SPAWN: begin
               taken_ff         <= spawn_go && found;
               spawn_counter_ff <= spawn_go ? SPAWN_CNT_W'(1)
                                            : spawn_counter_ff + SPAWN_CNT_W'(1);
               rot_cnt_ff       <= '0;
               state_ff         <= ST_ROTATE;
            end
            ST_ROTATE: begin
               if (step) begin
                  rot_cnt_ff <= rot_cnt_ff + SLOT_W'(1);
               end
               if (pass_last) begin
                  state_ff <= ST_FLUSH;
               end
            end
            ST_FLUSH: begin
               if (stat.flush_ok) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign ctrl.step   = step;
   assign ctrl.active = (state_ff == ST_ROTATE) &&
                        (CMP_W'(rot_cnt_ff) < CMP_W'(letter_slots_ff));
   assign ctrl.flush  = (state_ff == ST_FLUSH) && stat.flush_ok;
   assign ctrl.taken  = taken_ff;

   // ring of slots: the head unit rewrites the slot leaving cell zero
   assign chain[MAX_LETTERS] = head_next;

   for (genvar i = 0; i < MAX_LETTERS; i++) begin : g_cell
      bgs_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (step),
         .load_en    (load_vec[i]),
         .load_pos   (screen_width_ff),
         .load_glyph (glyph_ff),
         .neg_cw     (neg_cw),
         .nbr_in     (chain[i+1]),
         .slot_out   (chain[i]),
         .free       (cell_free[i])
      );
   end

   bgs_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .head_slot  (chain[0]),
      .neg_cw     (neg_cw),
      .char_width (char_width_ff),
      .ctrl       (ctrl),
      .head_next  (head_next),
      .stat       (stat),
      .rsp_ch     (rsp_ch)
   );

   `BGS_ASSERT_NOW(a_single_spawn, clock, reset, 1'b1, $onehot0(load_vec), "more than one slot loaded")
   `BGS_ASSERT_NOW(a_spawn_due, clock, reset, |load_vec, spawn_go, "slot loaded before spawn was due")
   `BGS_ASSERT_NEXT(a_pass_end, clock, reset, pass_last, state_ff == ST_FLUSH, "rotation pass did not end")

endmodule

`default_nettype wire
